FILE: hw/rtl/longest_equal_run_tracker_defines.svh
// Assertion macros shared by the longest equal run tracker RTL.
`ifndef LONGEST_EQUAL_RUN_TRACKER_DEFINES_SVH
`define LONGEST_EQUAL_RUN_TRACKER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LERT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LERT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lert_pkg.sv
// Shared constants, types and codes for the longest equal run tracker.
package lert_pkg;

   localparam int MAX_BITS_DEFAULT = 256;

   localparam int WORD_BITS  = 8;
   localparam int WORD_SHIFT = 3;

   localparam int LEN_W = 9;
   localparam int POS_W = 8;
   localparam int RUN_W = 9;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

   localparam logic REG_LENGTH = 1'b0;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_FLIP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic fetch;
      logic update;
      logic scan;
      logic load_result;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_sts_type;

endpackage

FILE: hw/rtl/lert_ctrl.sv
// Controller state machine: item handshake, sequencing and result valid.
module lert_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lert_pkg::dp_cmd_type  dp_cmd,
   input  lert_pkg::dp_sts_type  dp_sts
);

   lert_pkg::state_type state_ff;
   lert_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lert_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_cmd     = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lert_pkg::ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               dp_cmd.load_item = 1'b1;
               state_in         = lert_pkg::ST_FETCH;
            end
         end
         lert_pkg::ST_FETCH: begin
            dp_cmd.fetch = 1'b1;
            state_in     = lert_pkg::ST_UPDATE;
         end
         lert_pkg::ST_UPDATE: begin
            dp_cmd.update = 1'b1;
            state_in      = lert_pkg::ST_SCAN;
         end
         lert_pkg::ST_SCAN: begin
            dp_cmd.scan = 1'b1;
            if (dp_sts.scan_done) begin
               state_in = lert_pkg::ST_DONE;
            end
         end
         lert_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.load_result = 1'b1;
               state_in           = lert_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lert_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: hw/rtl/lert_datapath.sv
// Datapath: length register, word-wide bit store, update and run scan.
module lert_datapath #(
   parameter int MAX_BITS = lert_pkg::MAX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lert_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lert_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lert_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   input  logic [lert_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   output logic [lert_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,
   input  lert_pkg::dp_cmd_type                dp_cmd,
   output lert_pkg::dp_sts_type                dp_sts
);

   localparam int NUM_WORDS = (MAX_BITS + lert_pkg::WORD_BITS - 1) / lert_pkg::WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int IW        = lert_pkg::LEN_W;
   localparam int WB        = lert_pkg::WORD_BITS;
   localparam int WS        = lert_pkg::WORD_SHIFT;

   logic [lert_pkg::LEN_W-1:0] len_ff;
   logic [lert_pkg::LEN_W-1:0] len_in;
   logic [NUM_WORDS-1:0]       word_vld_ff;
   logic [NUM_WORDS-1:0]       word_vld_in;
   logic [WB-1:0]              word_mem_ff [NUM_WORDS];
   logic [WB-1:0]              rd_data_ff;
   logic                       pend_ff;
   logic                       pend_in;

   logic                       cmd_ff,   cmd_in;
   logic [lert_pkg::POS_W-1:0] pos_ff,   pos_in;
   logic                       bitv_ff,  bitv_in;
   logic                       bad_ff,   bad_in;
   logic [IW-1:0]              iss_ff,   iss_in;
   logic [lert_pkg::LEN_W-1:0] rem_ff,   rem_in;
   logic [lert_pkg::RUN_W-1:0] cur_ff,   cur_in;
   logic [lert_pkg::RUN_W-1:0] best_ff,  best_in;
   logic                       prev_ff,  prev_in;
   logic                       first_ff, first_in;
   logic [lert_pkg::RUN_W-1:0] run_out_ff, run_out_in;
   logic                       bad_out_ff, bad_out_in;

   logic [lert_pkg::LEN_W-1:0] eff_len;
   logic [IW+WS-1:0]           iss_bits;
   logic                       issue_more;
   logic [AW-1:0]              pos_word;
   logic [AW-1:0]              rd_addr;
   logic                       rd_en;
   logic                       wr_en;
   logic [WB-1:0]              wr_data;
   logic                       csr_wr;
   logic [lert_pkg::RUN_W-1:0] scan_cur;
   logic [lert_pkg::RUN_W-1:0] scan_best;
   logic                       scan_prev;
   logic                       scan_first;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[lert_pkg::CSR_ADDR_W-1] == lert_pkg::REG_LENGTH);
   assign len_in     = csr_wr ? csr_pwdata[lert_pkg::LEN_W-1:0] : len_ff;
   assign csr_prdata = (csr_paddr[lert_pkg::CSR_ADDR_W-1] == lert_pkg::REG_LENGTH) ?
                       {{(lert_pkg::CSR_DATA_W-lert_pkg::LEN_W){1'b0}}, len_ff} : '0;

   always_comb begin
      eff_len = len_ff;
      if (int'(len_ff) > MAX_BITS) begin
         eff_len = lert_pkg::LEN_W'(MAX_BITS);
      end
   end

   assign iss_bits   = {iss_ff, {WS{1'b0}}};
   assign issue_more = iss_bits < {{WS{1'b0}}, eff_len};
   assign pos_word   = AW'(pos_ff >> WS);
   assign rd_en      = dp_cmd.fetch || (dp_cmd.scan && issue_more);
   assign rd_addr    = dp_cmd.scan ? iss_ff[AW-1:0] : pos_word;
   assign wr_en      = dp_cmd.update && !bad_ff;

   always_comb begin
      wr_data = rd_data_ff;
      if (cmd_ff == lert_pkg::CMD_FLIP) begin
         wr_data[pos_ff[WS-1:0]] = ~rd_data_ff[pos_ff[WS-1:0]];
      end else begin
         wr_data[pos_ff[WS-1:0]] = bitv_ff;
      end
   end

   always_comb begin
      word_vld_in = word_vld_ff;
      if (wr_en) begin
         word_vld_in[pos_word] = 1'b1;
      end
   end

   // Fold one stored word into the running and best run lengths.
   always_comb begin
      scan_cur   = cur_ff;
      scan_best  = best_ff;
      scan_prev  = prev_ff;
      scan_first = first_ff;
      for (int i = 0; i < WB; i++) begin
         if (lert_pkg::LEN_W'(i) < rem_ff) begin
            if (!scan_first && (rd_data_ff[i] == scan_prev)) begin
               scan_cur = scan_cur + lert_pkg::RUN_W'(1);
            end else begin
               scan_cur = lert_pkg::RUN_W'(1);
            end
            scan_first = 1'b0;
            scan_prev  = rd_data_ff[i];
            if (scan_cur > scan_best) begin
               scan_best = scan_cur;
            end
         end
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      pos_in     = pos_ff;
      bitv_in    = bitv_ff;
      bad_in     = bad_ff;
      iss_in     = iss_ff;
      rem_in     = rem_ff;
      cur_in     = cur_ff;
      best_in    = best_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      pend_in    = pend_ff;
      run_out_in = run_out_ff;
      bad_out_in = bad_out_ff;
      if (dp_cmd.load_item) begin
         cmd_in   = req_tuser;
         pos_in   = req_tdata[lert_pkg::POS_W-1:0];
         bitv_in  = req_tdata[lert_pkg::POS_W];
         bad_in   = {1'b0, req_tdata[lert_pkg::POS_W-1:0]} >= eff_len;
         iss_in   = '0;
         rem_in   = eff_len;
         cur_in   = '0;
         best_in  = '0;
         prev_in  = 1'b0;
         first_in = 1'b1;
         pend_in  = 1'b0;
      end
      if (dp_cmd.scan) begin
         pend_in = issue_more;
         if (issue_more) begin
            iss_in = iss_ff + IW'(1);
         end
         if (pend_ff) begin
            cur_in   = scan_cur;
            best_in  = scan_best;
            prev_in  = scan_prev;
            first_in = scan_first;
            rem_in   = rem_ff - lert_pkg::LEN_W'(WB);
         end
      end
      if (dp_cmd.load_result) begin
         run_out_in = best_ff;
         bad_out_in = bad_ff;
      end
   end

   assign dp_sts.scan_done = !issue_more && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= lert_pkg::LEN_RESET;
         word_vld_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         len_ff      <= len_in;
         word_vld_ff <= word_vld_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      bitv_ff    <= bitv_in;
      bad_ff     <= bad_in;
      iss_ff     <= iss_in;
      rem_ff     <= rem_in;
      cur_ff     <= cur_in;
      best_ff    <= best_in;
      prev_ff    <= prev_in;
      first_ff   <= first_in;
      run_out_ff <= run_out_in;
      bad_out_ff <= bad_out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem_ff[pos_word] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= word_vld_ff[rd_addr] ? word_mem_ff[rd_addr] : '0;
      end
   end

   assign rsp_tdata = {{(lert_pkg::RSP_TDATA_W-lert_pkg::RUN_W){1'b0}}, run_out_ff};
   assign rsp_tuser = bad_out_ff;

endmodule

FILE: hw/rtl/longest_equal_run_tracker.sv
// Top level of the longest equal run tracker: controller, datapath, checks.
//
//   port group  direction  contents
//   req_*       in         stream of load or flip items
//   rsp_*       out        stream of results, one per item
//   csr_*       in/out     register port, length in use at address 0
//
// Between acceptances an item passes through the fetch, update, scan and done
// states, no word being scanned when L, the effective length, is zero; the scan
// reads one 8-bit word of the bit store per cycle and folds it in the cycle after.
// Reset clears the control state and the per-word valid bits of the bit store, so
// no clearing pass runs. A finished result waits in the output register while the
// next item is taken; a scan that finishes while it still waits holds until taken.

`include "longest_equal_run_tracker_defines.svh"

module longest_equal_run_tracker #(
   parameter int MAX_BITS = lert_pkg::MAX_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lert_pkg::REQ_TDATA_W-1:0] req_tdata,   // position, bit_value
   input  logic                             req_tuser,   // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lert_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // longest_run
   output logic                             rsp_tuser,   // bad_position
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lert_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lert_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lert_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   lert_pkg::dp_cmd_type dp_cmd;
   lert_pkg::dp_sts_type dp_sts;

   lert_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

   lert_datapath #(
      .MAX_BITS (MAX_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts)
   );

   `LERT_ASSERT_NEXT(a_accept_busy, req_tvalid && req_tready, !req_tready, "taken while busy")
   `LERT_ASSERT_SAME(a_rsp_overrun, dp_cmd.load_result, !rsp_tvalid || rsp_tready, "overrun")
   `LERT_ASSERT_SAME(a_single_command, 1'b1, $onehot0(dp_cmd), "two datapath commands")

endmodule
